// ----- rtl/twc_pkg.sv -----
package twc_pkg;

   // fixed field and register widths
   localparam int TALLY_BITS     = 21;
   localparam int THRESH_BITS    = 8;
   localparam int MARGIN_BITS    = 10;
   localparam int SIZE_BITS      = 11;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEPTH_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MARGIN_TOP      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MARGIN_BOTTOM   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MARGIN_LEFT     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MARGIN_RIGHT    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT    = 3'd6;

   // register reset values
   localparam logic [THRESH_BITS-1:0] RST_DEPTH_THRESHOLD = 8'd20;
   localparam logic [MARGIN_BITS-1:0] RST_MARGIN_TOP      = 10'd30;
   localparam logic [MARGIN_BITS-1:0] RST_MARGIN_BOTTOM   = 10'd30;
   localparam logic [MARGIN_BITS-1:0] RST_MARGIN_LEFT     = 10'd30;
   localparam logic [MARGIN_BITS-1:0] RST_MARGIN_RIGHT    = 10'd100;
   localparam logic [SIZE_BITS-1:0]   RST_FRAME_WIDTH     = 11'd512;
   localparam logic [SIZE_BITS-1:0]   RST_FRAME_HEIGHT    = 11'd424;

   typedef struct packed {
      logic [THRESH_BITS-1:0] depth_threshold;
      logic [MARGIN_BITS-1:0] margin_top;
      logic [MARGIN_BITS-1:0] margin_bottom;
      logic [MARGIN_BITS-1:0] margin_left;
      logic [MARGIN_BITS-1:0] margin_right;
      logic [SIZE_BITS-1:0]   frame_width;
      logic [SIZE_BITS-1:0]   frame_height;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;    // input beat taken this cycle
      logic div_load;  // snapshot sums into the divider, clear accumulators
      logic div_step;  // one quotient bit
      logic rsp_load;  // update held centroid and result registers
   } cmd_type;

endpackage

// ----- rtl/threshold_window_centroid.sv -----
// Channel  Direction  Beat contents
// req      in         tdata: depth_value, pixel_col, pixel_row; tlast: frame_last
// rsp      out        tdata: centroid_col, centroid_row, hit_count; tuser: found
// csr      in         csr_we, csr_index, csr_wdata; write only, no wait
//
// Within a frame one pixel is taken per cycle. The frame_last beat starts a
// restoring divider that shares one step per cycle between both axes:
// req_tready stays low while the divider runs, longer while a previous result
// is still held on rsp. A result waiting on rsp does not block pixels of the
// next frame. Reset is synchronous: registers take their defaults and the
// sums, tally and held centroid clear at once.
module threshold_window_centroid #(
   parameter int COORD_BITS = 10,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // depth_value, pixel_col, pixel_row from bit 0 up, zero padded
   input  logic [((PIXEL_BITS+2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                                        req_tvalid,
   input  logic                                        req_tlast,
   output logic                                        req_tready,
   // centroid_col, centroid_row, hit_count from bit 0 up, zero padded
   output logic [((2*COORD_BITS+twc_pkg::TALLY_BITS+7)/8)*8-1:0] rsp_tdata,
   // found
   output logic                                        rsp_tuser,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   input  logic                                        csr_we,
   input  logic [twc_pkg::CSR_INDEX_BITS-1:0]          csr_index,
   input  logic [twc_pkg::CSR_DATA_BITS-1:0]           csr_wdata
);
   import twc_pkg::*;

   localparam int OUT_DATA_BITS = ((2*COORD_BITS + TALLY_BITS + 7) / 8) * 8;

   cfg_type               cfg;
   cmd_type               cmd;
   logic [COORD_BITS-1:0] centroid_col, centroid_row;
   logic [TALLY_BITS-1:0] hit_count;

   twc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   twc_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   twc_dpath #(
      .COORD_BITS (COORD_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .depth_value  (req_tdata[PIXEL_BITS-1:0]),
      .pixel_col    (req_tdata[PIXEL_BITS +: COORD_BITS]),
      .pixel_row    (req_tdata[PIXEL_BITS+COORD_BITS +: COORD_BITS]),
      .centroid_col (centroid_col),
      .centroid_row (centroid_row),
      .hit_count    (hit_count),
      .found        (rsp_tuser)
   );

   assign rsp_tdata = OUT_DATA_BITS'({hit_count, centroid_row, centroid_col});

endmodule

// ----- rtl/twc_csr.sv -----
module twc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [twc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [twc_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output twc_pkg::cfg_type                     cfg
);
   import twc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEPTH_THRESHOLD: cfg_in.depth_threshold = csr_wdata[THRESH_BITS-1:0];
            CSR_MARGIN_TOP:      cfg_in.margin_top      = csr_wdata[MARGIN_BITS-1:0];
            CSR_MARGIN_BOTTOM:   cfg_in.margin_bottom   = csr_wdata[MARGIN_BITS-1:0];
            CSR_MARGIN_LEFT:     cfg_in.margin_left     = csr_wdata[MARGIN_BITS-1:0];
            CSR_MARGIN_RIGHT:    cfg_in.margin_right    = csr_wdata[MARGIN_BITS-1:0];
            CSR_FRAME_WIDTH:     cfg_in.frame_width     = csr_wdata[SIZE_BITS-1:0];
            CSR_FRAME_HEIGHT:    cfg_in.frame_height    = csr_wdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_threshold <= RST_DEPTH_THRESHOLD;
         cfg_ff.margin_top      <= RST_MARGIN_TOP;
         cfg_ff.margin_bottom   <= RST_MARGIN_BOTTOM;
         cfg_ff.margin_left     <= RST_MARGIN_LEFT;
         cfg_ff.margin_right    <= RST_MARGIN_RIGHT;
         cfg_ff.frame_width     <= RST_FRAME_WIDTH;
         cfg_ff.frame_height    <= RST_FRAME_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/twc_ctrl.sv -----
module twc_ctrl #(
   parameter int COORD_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tlast,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output twc_pkg::cmd_type  cmd
);
   import twc_pkg::*;

   localparam int CNT_BITS = $clog2(COORD_BITS + 1);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(COORD_BITS - 1);
   localparam logic [CNT_BITS-1:0] DONE_STEP = CNT_BITS'(COORD_BITS);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] step_cnt_ff, step_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (req_tvalid && req_tlast) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (step_cnt_ff == LAST_STEP) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) state_in = ST_ACCUM;
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   // outputs and commands
   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_ACCUM: begin
            req_tready   = 1'b1;
            cmd.accept   = req_tvalid;
            cmd.div_load = req_tvalid && req_tlast;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_HOLD: begin
            cmd.rsp_load = out_free;
         end
         default: ;
      endcase
   end

   // step counter and result valid
   always_comb begin
      step_cnt_in = step_cnt_ff;
      if (cmd.div_load)      step_cnt_in = '0;
      else if (cmd.div_step) step_cnt_in = step_cnt_ff + 1'b1;
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while a beat is pending");

   // the last pixel of a frame starts the divider
   a_last_starts_div: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (state_ff == ST_DIVIDE))
      else $error("frame end did not start the divider");

   // the result is only loaded after all quotient bits
   a_steps_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> (step_cnt_ff == DONE_STEP))
      else $error("divider left before all steps");

endmodule

// ----- rtl/twc_dpath.sv -----
module twc_dpath #(
   parameter int COORD_BITS = 10,
   parameter int PIXEL_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  twc_pkg::cmd_type               cmd,
   input  twc_pkg::cfg_type               cfg,
   input  logic [PIXEL_BITS-1:0]          depth_value,
   input  logic [COORD_BITS-1:0]          pixel_col,
   input  logic [COORD_BITS-1:0]          pixel_row,
   output logic [COORD_BITS-1:0]          centroid_col,
   output logic [COORD_BITS-1:0]          centroid_row,
   output logic [twc_pkg::TALLY_BITS-1:0] hit_count,
   output logic                           found
);
   import twc_pkg::*;

   localparam int SUM_BITS = COORD_BITS + TALLY_BITS;
   localparam int CMP_BITS = ((COORD_BITS > MARGIN_BITS) ? COORD_BITS : MARGIN_BITS) + 1;
   localparam int DEP_BITS = (PIXEL_BITS > THRESH_BITS) ? PIXEL_BITS : THRESH_BITS;

   logic [SUM_BITS-1:0]   col_sum_ff, col_sum_in, col_sum_next;
   logic [SUM_BITS-1:0]   row_sum_ff, row_sum_in, row_sum_next;
   logic [TALLY_BITS-1:0] tally_ff, tally_in, tally_next;

   logic [TALLY_BITS-1:0] div_ff, div_in;
   logic [TALLY_BITS-1:0] col_rem_ff, col_rem_in, row_rem_ff, row_rem_in;
   logic [COORD_BITS-1:0] col_q_ff, col_q_in, row_q_ff, row_q_in;

   logic [COORD_BITS-1:0] held_col_ff, held_col_in, held_row_ff, held_row_in;
   logic [TALLY_BITS-1:0] hit_ff, hit_in;
   logic                  found_ff, found_in;

   logic                  depth_ok, row_ok, col_ok, add_en;
   logic [TALLY_BITS:0]   col_trial, row_trial, div_ext, col_diff, row_diff;
   logic                  col_ge, row_ge;

   // window and threshold test, compared without wrap
   always_comb begin
      depth_ok = DEP_BITS'(depth_value) < DEP_BITS'(cfg.depth_threshold);
      row_ok   = (CMP_BITS'(pixel_row) > CMP_BITS'(cfg.margin_top))
              && ((CMP_BITS'(pixel_row) + CMP_BITS'(cfg.margin_bottom))
                  < CMP_BITS'(cfg.frame_height));
      col_ok   = (CMP_BITS'(pixel_col) > CMP_BITS'(cfg.margin_left))
              && ((CMP_BITS'(pixel_col) + CMP_BITS'(cfg.margin_right))
                  < CMP_BITS'(cfg.frame_width));
      add_en   = cmd.accept && depth_ok && row_ok && col_ok && (tally_ff != TALLY_MAX);
   end

   // running sums; cleared once the frame is handed to the divider
   always_comb begin
      col_sum_next = col_sum_ff;
      row_sum_next = row_sum_ff;
      tally_next   = tally_ff;
      if (add_en) begin
         col_sum_next = col_sum_ff + SUM_BITS'(pixel_col);
         row_sum_next = row_sum_ff + SUM_BITS'(pixel_row);
         tally_next   = tally_ff + 1'b1;
      end
      if (cmd.div_load) begin
         col_sum_in = '0;
         row_sum_in = '0;
         tally_in   = '0;
      end else begin
         col_sum_in = col_sum_next;
         row_sum_in = row_sum_next;
         tally_in   = tally_next;
      end
   end

   // restoring divider, one quotient bit per step for both axes; the
   // quotient fits in COORD_BITS so the upper dividend bits start as remainder
   always_comb begin
      div_ext   = {1'b0, div_ff};
      col_trial = {col_rem_ff, col_q_ff[COORD_BITS-1]};
      row_trial = {row_rem_ff, row_q_ff[COORD_BITS-1]};
      col_ge    = col_trial >= div_ext;
      row_ge    = row_trial >= div_ext;
      col_diff  = col_trial - div_ext;
      row_diff  = row_trial - div_ext;

      div_in     = div_ff;
      col_rem_in = col_rem_ff;
      row_rem_in = row_rem_ff;
      col_q_in   = col_q_ff;
      row_q_in   = row_q_ff;
      if (cmd.div_load) begin
         div_in     = tally_next;
         col_rem_in = col_sum_next[SUM_BITS-1:COORD_BITS];
         row_rem_in = row_sum_next[SUM_BITS-1:COORD_BITS];
         col_q_in   = col_sum_next[COORD_BITS-1:0];
         row_q_in   = row_sum_next[COORD_BITS-1:0];
      end else if (cmd.div_step) begin
         col_rem_in = col_ge ? col_diff[TALLY_BITS-1:0] : col_trial[TALLY_BITS-1:0];
         row_rem_in = row_ge ? row_diff[TALLY_BITS-1:0] : row_trial[TALLY_BITS-1:0];
         col_q_in   = {col_q_ff[COORD_BITS-2:0], col_ge};
         row_q_in   = {row_q_ff[COORD_BITS-2:0], row_ge};
      end
   end

   // result: an empty frame keeps the previous centroid
   always_comb begin
      held_col_in = held_col_ff;
      held_row_in = held_row_ff;
      hit_in      = hit_ff;
      found_in    = found_ff;
      if (cmd.rsp_load) begin
         hit_in   = div_ff;
         found_in = (div_ff != '0);
         if (div_ff != '0) begin
            held_col_in = col_q_ff;
            held_row_in = row_q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_sum_ff  <= '0;
         row_sum_ff  <= '0;
         tally_ff    <= '0;
         held_col_ff <= '0;
         held_row_ff <= '0;
      end else begin
         col_sum_ff  <= col_sum_in;
         row_sum_ff  <= row_sum_in;
         tally_ff    <= tally_in;
         held_col_ff <= held_col_in;
         held_row_ff <= held_row_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      div_ff     <= div_in;
      col_rem_ff <= col_rem_in;
      row_rem_ff <= row_rem_in;
      col_q_ff   <= col_q_in;
      row_q_ff   <= row_q_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
   end

   assign centroid_col = held_col_ff;
   assign centroid_row = held_row_ff;
   assign hit_count    = hit_ff;
   assign found        = found_ff;

endmodule
